FILE: rtl/chd_pkg.sv
package chd_pkg;

   // fixed field widths
   localparam int CHAR_W     = 8;
   localparam int HASH_W     = 64;
   localparam int DUP_W      = 32;
   localparam int STORED_W   = 7;
   localparam int RSP_DATA_W = 48;

   // default depth of the seen-hash store
   localparam int TABLE_DEPTH_DEF = 64;

   // hash handed from the front to the queue
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } hash_push_type;

   // head of the queue as seen by the back
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } hash_head_type;

   // queue occupancy status towards the front
   typedef struct packed {
      logic full;
   } queue_status_type;

   // lookup sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_CMP,
      BK_RESOLVE
   } back_state_type;

endpackage

FILE: rtl/chd_front.sv
module chd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [chd_pkg::CHAR_W-1:0] req_tdata,
   input  logic                       req_tlast,
   input  chd_pkg::queue_status_type  q_status,
   output chd_pkg::hash_push_type     push
);
   import chd_pkg::*;

   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic [HASH_W-1:0] lowered;
   logic [HASH_W-1:0] folded;
   logic              accept;

   // take bytes whenever the queue can hold a finished hash
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // ascii upper case to lower case, other bytes unchanged
   always_comb begin
      if (req_tdata inside {[8'h41:8'h5a]}) begin
         lowered = HASH_W'(req_tdata) + HASH_W'(8'h20);
      end else begin
         lowered = HASH_W'(req_tdata);
      end
   end

   // hash * 31 as a shift and subtract, plus the lowered byte
   assign folded = (hash_ff << 5) - hash_ff + lowered;

   // accumulator update, cleared after the last byte of a name
   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = req_tlast ? '0 : folded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // finished hash goes to the queue
   assign push.valid = accept && req_tlast;
   assign push.hash  = folded;

endmodule

FILE: rtl/chd_queue.sv
module chd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  chd_pkg::hash_push_type    push,
   input  logic                      pop,
   output chd_pkg::hash_head_type    head,
   output chd_pkg::queue_status_type status
);
   import chd_pkg::*;

   logic [HASH_W-1:0] slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;

   assign do_push = push.valid && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.hash;
      end
   end

   assign head.valid  = (count_ff != 2'd0);
   assign head.hash   = slot_ff[rd_ptr_ff];
   assign status.full = (count_ff == 2'd2);

endmodule

FILE: rtl/chd_back.sv
module chd_back #(
   parameter int TABLE_DEPTH = chd_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chd_pkg::hash_head_type       head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_dup,
   output logic                         rsp_full,
   output logic [chd_pkg::DUP_W-1:0]    rsp_dup_total,
   output logic [chd_pkg::STORED_W-1:0] rsp_stored_total
);
   import chd_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [FILL_W-1:0] DEPTH_CNT = FILL_W'(TABLE_DEPTH);

   back_state_type     state_ff;
   back_state_type     state_in;
   logic [HASH_W-1:0]  hash_ff;
   logic [HASH_W-1:0]  hash_in;
   logic               hit_ff;
   logic               hit_in;
   logic [FILL_W-1:0]  idx_ff;
   logic [FILL_W-1:0]  idx_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [DUP_W-1:0]   dup_ff;
   logic [DUP_W-1:0]   dup_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               out_dup_ff;
   logic               out_dup_in;
   logic               out_full_ff;
   logic               out_full_in;
   logic [DUP_W-1:0]   out_total_ff;
   logic [DUP_W-1:0]   out_total_in;
   logic [FILL_W-1:0]  out_fill_ff;
   logic [FILL_W-1:0]  out_fill_in;
   logic [FILL_W+STORED_W-1:0] fill_wide;
   logic               mem_we;
   logic               mem_re;
   logic               slot_free;
   logic [HASH_W-1:0]  seen_ff [TABLE_DEPTH];
   logic [HASH_W-1:0]  rd_data_ff;

   assign slot_free = !out_valid_ff || rsp_tready;

   // lookup sequencer: stored hashes are read and compared one at a time, in order
   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      hit_in       = hit_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      dup_in       = dup_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_dup_in   = out_dup_ff;
      out_full_in  = out_full_ff;
      out_total_in = out_total_ff;
      out_fill_in  = out_fill_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               hash_in = head.hash;
               hit_in  = 1'b0;
               idx_in  = '0;
               state_in = (fill_ff == '0) ? BK_RESOLVE : BK_READ;
            end
         end
         BK_READ: begin
            mem_re   = 1'b1;
            state_in = BK_CMP;
         end
         BK_CMP: begin
            if (rd_data_ff == hash_ff) begin
               hit_in   = 1'b1;
               state_in = BK_RESOLVE;
            end else if (idx_ff == fill_ff - FILL_W'(1)) begin
               state_in = BK_RESOLVE;
            end else begin
               idx_in   = idx_ff + FILL_W'(1);
               state_in = BK_READ;
            end
         end
         BK_RESOLVE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_dup_in   = hit_ff;
               out_full_in  = 1'b0;
               if (hit_ff) begin
                  if (dup_ff != '1) begin
                     dup_in = dup_ff + DUP_W'(1);
                  end
               end else if (fill_ff != DEPTH_CNT) begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + FILL_W'(1);
               end else begin
                  out_full_in = 1'b1;
               end
               out_total_in = dup_in;
               out_fill_in  = fill_in;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         dup_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dup_ff       <= dup_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      hash_ff      <= hash_in;
      hit_ff       <= hit_in;
      idx_ff       <= idx_in;
      out_dup_ff   <= out_dup_in;
      out_full_ff  <= out_full_in;
      out_total_ff <= out_total_in;
      out_fill_ff  <= out_fill_in;
   end

   // seen-hash memory, filled in order, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_ff[fill_ff[IDX_W-1:0]] <= hash_ff;
      end
      if (mem_re) begin
         rd_data_ff <= seen_ff[idx_ff[IDX_W-1:0]];
      end
   end

   // stored count reported in seven bits
   assign fill_wide        = (FILL_W + STORED_W)'(out_fill_ff);
   assign rsp_tvalid       = out_valid_ff;
   assign rsp_dup          = out_dup_ff;
   assign rsp_full         = out_full_ff;
   assign rsp_dup_total    = out_total_ff;
   assign rsp_stored_total = fill_wide[STORED_W-1:0];

   // fill count never passes the depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_CNT)
      else $error("fill count beyond table depth");

   // compare only looks at stored entries
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CMP) |-> (idx_ff < fill_ff))
      else $error("lookup index beyond fill count");

   // fill count moves only when a name is resolved
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         ($past(state_ff) == BK_RESOLVE && fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("fill count changed outside resolve");

   // duplicate counter never goes down
   a_dup_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (dup_ff >= $past(dup_ff)))
      else $error("duplicate counter decreased");

   // a new result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_dup_total)))
      else $error("pending result overwritten");

endmodule

FILE: rtl/case_insensitive_hash_dedup_core.sv
// channel | ports                     | fields, lowest bit up
// req     | req_tvalid/tready/tdata/tlast | char_code[7:0]; tlast = last_char
// rsp     | rsp_tvalid/tready/tdata   | is_duplicate, table_full, dup_total[31:0],
//         |                           | stored_total[6:0], zero fill to 48 bits
//
// each name byte is folded into the hash; bytes stream back to back unless the queue is full
// a finished hash waits in a two-entry queue for the lookup sequencer
// lookup reads and compares the stored hashes one at a time, up to and including a hit,
//   through the single read port of the seen-hash memory; a miss then writes the next free slot
// reset clears the accumulator, queue, fill count and duplicate counter; no clearing pass
// req_tready drops only while the queue holds two unresolved names; rsp stalls hold the lookup
module case_insensitive_hash_dedup_core #(
   parameter int TABLE_DEPTH = chd_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [chd_pkg::CHAR_W-1:0]     req_tdata,  // char_code
   input  logic                           req_tlast,  // last_char
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [chd_pkg::RSP_DATA_W-1:0] rsp_tdata   // is_duplicate, table_full,
                                                      // dup_total, stored_total
);
   import chd_pkg::*;

   hash_push_type    push;
   hash_head_type    head;
   queue_status_type q_status;
   logic             pop;
   logic             rsp_dup;
   logic             rsp_full;
   logic [DUP_W-1:0]    rsp_dup_total;
   logic [STORED_W-1:0] rsp_stored_total;

   // byte intake and hashing
   chd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push)
   );

   // finished hashes between front and back
   chd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   // lookup, insert and counters
   chd_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_dup          (rsp_dup),
      .rsp_full         (rsp_full),
      .rsp_dup_total    (rsp_dup_total),
      .rsp_stored_total (rsp_stored_total)
   );

   // result packing
   assign rsp_tdata = {
      {(RSP_DATA_W - 2 - DUP_W - STORED_W){1'b0}},
      rsp_stored_total,
      rsp_dup_total,
      rsp_full,
      rsp_dup
   };

endmodule

FILE: sim/tb.sv
module tb;
   import chd_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1850;
   localparam int POOL_SIZE    = 40;
   localparam int NAME_MAX     = 12;
   localparam int LOOKUP_MAX   = 2 + 2 * DEPTH;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_MAX   = 40;
   localparam int DIRECTED_N   = 24;

   // one result item, as predicted
   typedef struct packed {
      logic                dup;
      logic                full;
      logic [DUP_W-1:0]    dups;
      logic [STORED_W-1:0] stored;
   } verdict_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
      bit                typed;
      verdict_type       want;
   } row_type;

   localparam verdict_type NO_WANT = '0;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata  = '0;    // char_code
   logic                  req_tlast  = 1'b0;  // last_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // is_duplicate, table_full,
                                              // dup_total, stored_total

   // predictor state
   logic [HASH_W-1:0] name_hash = '0;
   logic [HASH_W-1:0] seen_hashes [DEPTH];
   int unsigned       seen_count = 0;
   logic [DUP_W-1:0]  dup_count  = '0;

   verdict_type pending_verdicts [$];
   bit          failed     = 1'b0;
   int          mismatches = 0;
   int          bytes_sent = 0;

   // idling controls for the sender and the receiver
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_request       = 1'b0;

   // directed names: case folding, lowering edges, zero and all-ones bytes, collisions
   row_type directed_rows [DIRECTED_N] = '{
      '{8'h41, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd0, 7'd1}},  // single-byte name, upper case
      '{8'h61, 1'b1, 1'b1, '{1'b1, 1'b0, 32'd1, 7'd1}},  // same name in lower case
      '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd1, 7'd2}},  // hash of zero
      '{8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd1, 7'd3}},  // top byte value
      '{8'h5A, 1'b0, 1'b0, NO_WANT},                     // 'Z' then '['
      '{8'h5B, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd1, 7'd4}},
      '{8'h7A, 1'b0, 1'b0, NO_WANT},                     // 'z' then '[' matches
      '{8'h5B, 1'b1, 1'b1, '{1'b1, 1'b0, 32'd2, 7'd4}},
      '{8'h40, 1'b1, 1'b0, NO_WANT},                     // just below 'A'
      '{8'h60, 1'b1, 1'b0, NO_WANT},                     // its lowered twin, no fold
      '{8'h01, 1'b0, 1'b0, NO_WANT},                     // two byte strings with
      '{8'h3F, 1'b1, 1'b0, NO_WANT},                     //   one and the same hash
      '{8'h02, 1'b0, 1'b0, NO_WANT},
      '{8'h20, 1'b1, 1'b0, NO_WANT},
      '{8'hC1, 1'b1, 1'b0, NO_WANT},                     // high bytes are never lowered
      '{8'hE1, 1'b1, 1'b0, NO_WANT},
      '{8'h48, 1'b0, 1'b0, NO_WANT},                     // "HeLo"
      '{8'h65, 1'b0, 1'b0, NO_WANT},
      '{8'h4C, 1'b0, 1'b0, NO_WANT},
      '{8'h6F, 1'b1, 1'b0, NO_WANT},
      '{8'h68, 1'b0, 1'b0, NO_WANT},                     // "hElO", a duplicate
      '{8'h45, 1'b0, 1'b0, NO_WANT},
      '{8'h6C, 1'b0, 1'b0, NO_WANT},
      '{8'h4F, 1'b1, 1'b0, NO_WANT}
   };

   case_insensitive_hash_dedup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // fold one byte into the name hash; on the last byte look the name up
   task automatic fold_byte(input logic [CHAR_W-1:0] code, input logic last,
                            output bit done, output verdict_type v);
      logic [HASH_W-1:0] lowered;
      logic [HASH_W-1:0] h;
      bit                hit;
      lowered = HASH_W'(code);
      if (code >= 8'h41 && code <= 8'h5A) lowered = lowered + 64'h20;
      h    = name_hash * 64'd31 + lowered;
      done = last;
      v    = '0;
      hit  = 1'b0;
      if (!last) begin
         name_hash = h;
      end else begin
         for (int i = 0; i < seen_count; i++)
            if (seen_hashes[i] == h) hit = 1'b1;
         // the saturation of the duplicate count is out of reach in a run this short
         if (hit) begin
            v.dup = 1'b1;
            if (dup_count != '1) dup_count = dup_count + DUP_W'(1);
         end else if (seen_count < DEPTH) begin
            seen_hashes[seen_count] = h;
            seen_count++;
         end else begin
            v.full = 1'b1;
         end
         name_hash = '0;
         v.dups    = dup_count;
         v.stored  = STORED_W'(seen_count);
      end
   endtask

   // offer one byte, wait for it to be taken, then predict
   task automatic send_byte(input logic [CHAR_W-1:0] code, input logic last,
                            input bit typed, input verdict_type want);
      bit          done;
      verdict_type v;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      fold_byte(code, last, done, v);
      if (done) pending_verdicts.insert(pending_verdicts.size(), typed ? want : v);
      bytes_sent++;
   endtask

   task automatic report(input string field, input logic [63:0] want,
                         input logic [63:0] got);
      failed = 1'b1;
      if (mismatches < REPORT_MAX)
         $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
   endtask

   // compare one result item with the oldest expectation
   task automatic check_verdict();
      verdict_type want;
      if (pending_verdicts.size() == 0) begin
         report("unexpected result", '0, 64'(rsp_tdata));
      end else begin
         want = pending_verdicts.pop_front();
         if (rsp_tdata[0] !== want.dup)
            report("is_duplicate", 64'(want.dup), 64'(rsp_tdata[0]));
         if (rsp_tdata[1] !== want.full)
            report("table_full", 64'(want.full), 64'(rsp_tdata[1]));
         if (rsp_tdata[33:2] !== want.dups)
            report("dup_total", 64'(want.dups), 64'(rsp_tdata[33:2]));
         if (rsp_tdata[40:34] !== want.stored)
            report("stored_total", 64'(want.stored), 64'(rsp_tdata[40:34]));
      end
   endtask

   // receiver: check taken items, stall at random, one long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_verdict();
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // stimulus
   initial begin
      logic [CHAR_W-1:0] pool [POOL_SIZE][NAME_MAX];
      int                pool_len [POOL_SIZE];
      logic [CHAR_W-1:0] name_buf [NAME_MAX];
      int                len;
      int                pick;
      int                idx;
      int                names_sent;
      int                phase;

      // pool of mostly lower-case names, reused with random case to make duplicates
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_len[p] = $urandom_range(1, 8);
         for (int i = 0; i < NAME_MAX; i++)
            pool[p][i] = ($urandom_range(99) < 85) ? CHAR_W'(8'h61 + $urandom_range(25))
                                                   : CHAR_W'($urandom_range(255));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r])
         send_byte(directed_rows[r].code, directed_rows[r].last,
                   directed_rows[r].typed, directed_rows[r].want);

      // random names until enough bytes have gone in
      names_sent = 0;
      while (bytes_sent < DIRECTED_N + RANDOM_ITEMS) begin
         phase = (names_sent / 40) % 4;
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 54;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 54;
            end
            default: begin
               sender_idle_pct    = 6;
               receiver_stall_pct = 6;
            end
         endcase
         if (names_sent == 60) hold_request = 1'b1;

         pick = $urandom_range(99);
         if (pick < 80) begin
            // pool name with random case, sometimes one byte changed
            idx = $urandom_range(POOL_SIZE - 1);
            len = pool_len[idx];
            for (int i = 0; i < len; i++) begin
               name_buf[i] = pool[idx][i];
               if (name_buf[i] >= 8'h61 && name_buf[i] <= 8'h7A && $urandom_range(1))
                  name_buf[i] = name_buf[i] - 8'h20;
            end
            if (pick >= 70) name_buf[$urandom_range(len - 1)] = CHAR_W'($urandom_range(255));
         end else begin
            // noise: any bytes, now and then a long name
            len = ($urandom_range(19) == 0) ? NAME_MAX : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               name_buf[i] = CHAR_W'($urandom_range(255));
         end

         for (int i = 0; i < len; i++)
            send_byte(name_buf[i], (i == len - 1), 1'b0, NO_WANT);
         names_sent++;
      end

      // drain
      req_tvalid        <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (LOOKUP_MAX + 20) @(posedge clock);
      if (!failed)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #(8 * 2_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
